// ===== hdl/bcd_pkg.sv =====
// shared types and constants for the button click detector
// no dependencies; imported by every module of the block
package bcd_pkg;

  // parameter defaults
  localparam int unsigned SLOTS_DEF       = 8;
  localparam int unsigned PINS_DEF        = 8;
  localparam int unsigned COUNT_WIDTH_DEF = 16;

  // fixed field widths
  localparam int unsigned PIN_W       = 8;   // pin_levels
  localparam int unsigned FIRE_W      = 8;   // fire_mask
  localparam int unsigned ACTIVE_W    = 4;   // active_slots
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned SLOT_WORD_W = 32;
  localparam int unsigned PIN_SEL_W   = 3;

  // slot word layout
  localparam int unsigned PIN_LSB  = 16;
  localparam int unsigned ACT_BIT  = 19;
  localparam int unsigned MODE_LSB = 20;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_SLOTS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_PAIR_0  = 3'd1;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_SINGLE = 2'd1,
    MODE_DOUBLE = 2'd2,
    MODE_LONG   = 2'd3
  } bcd_mode_e;

  // per-lane control strobes
  typedef struct packed {
    logic tick;    // tick transfer and lane is active
    logic cfg_wr;  // lane slot word written
  } bcd_lane_ctl_t;

endpackage

// ===== hdl/button_click_detector_unit.sv =====
// top level of the button click detector: config registers, slot lanes, merge
// depends on bcd_pkg, bcd_slot_lane, bcd_merge
//
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata[7:0] pin_levels
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata[7:0] fire_mask
// cfg       in   cfg_we_i                     cfg_index_i, cfg_data_i
//
// one tick per cycle unless stalled; active lanes evaluate in the same cycle
// fire mask shows in the output register the cycle after the tick transfer
// a full output register held by m_axis_tready low stalls the input side
// reset clears settings and all slot state at once, no clearing pass
module button_click_detector_unit #(
  parameter int unsigned SLOTS       = bcd_pkg::SLOTS_DEF,
  parameter int unsigned PINS        = bcd_pkg::PINS_DEF,
  parameter int unsigned COUNT_WIDTH = bcd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [bcd_pkg::PIN_W-1:0]        s_axis_tdata,   // [7:0] pin_levels
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [bcd_pkg::FIRE_W-1:0]       m_axis_tdata,   // [7:0] fire_mask
  input  logic                             cfg_we_i,
  input  logic [bcd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bcd_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import bcd_pkg::*;

  logic [ACTIVE_W-1:0] active_slots_q;
  logic                tick_xfer;
  logic [SLOTS-1:0]    lane_fire;

  assign tick_xfer = s_axis_tvalid && s_axis_tready;

  // slot count register; slot words live in the lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_slots_q <= '0;
    end else if (cfg_we_i && cfg_index_i == REG_ACTIVE_SLOTS) begin
      active_slots_q <= cfg_data_i[ACTIVE_W-1:0];
    end
  end

  for (genvar s = 0; s < SLOTS; s++) begin : g_lane
    bcd_lane_ctl_t lane_ctl;

    // slot 2k sits in the low half of pair k, slot 2k+1 in the high half
    assign lane_ctl.cfg_wr = cfg_we_i &&
      (cfg_index_i == REG_SLOT_PAIR_0 + CFG_IDX_W'(s / 2));
    // slots at or above the active count are skipped and keep their state
    assign lane_ctl.tick = tick_xfer && (ACTIVE_W'(s) < active_slots_q);

    bcd_slot_lane #(
      .PINS        (PINS),
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (lane_ctl),
      .cfg_word_i (cfg_data_i[(s % 2) * SLOT_WORD_W +: SLOT_WORD_W]),
      .levels_i   (s_axis_tdata),
      .fire_o     (lane_fire[s])
    );
  end

  // merge lane results into the output register
  bcd_merge #(
    .SLOTS (SLOTS)
  ) u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .fire_i    (lane_fire),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_mask_o  (m_axis_tdata)
  );

  // no active slot means an empty mask
  a_idle_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_xfer && active_slots_q == '0) |=> m_axis_tdata == '0)
    else $error("fire bit set with no active slot");

endmodule

// ===== hdl/bcd_slot_lane.sv =====
// one slot lane: slot settings, hold counter and click progress
// depends on bcd_pkg
module bcd_slot_lane #(
  parameter int unsigned PINS        = bcd_pkg::PINS_DEF,
  parameter int unsigned COUNT_WIDTH = bcd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bcd_pkg::bcd_lane_ctl_t           ctl_i,
  input  logic [bcd_pkg::SLOT_WORD_W-1:0]  cfg_word_i,
  input  logic [bcd_pkg::PIN_W-1:0]        levels_i,
  output logic                             fire_o
);
  import bcd_pkg::*;

  localparam logic [1:0] PROG_IDLE   = 2'd0;
  localparam logic [1:0] PROG_FIRST  = 2'd1;
  localparam logic [1:0] PROG_DOUBLE = 2'd2;
  localparam logic [PIN_SEL_W:0] PinLimit = (PIN_SEL_W + 1)'(PINS);

  logic [COUNT_WIDTH-1:0] thr_q;
  logic [PIN_SEL_W-1:0]   pin_q;
  logic                   act_q;
  bcd_mode_e              mode_q;
  logic [COUNT_WIDTH-1:0] hold_q, hold_d, hold_inc, hold_nx;
  logic [1:0]             prog_q, prog_d;
  logic                   lvl, pressed, below;

  always_comb begin
    lvl      = ({1'b0, pin_q} < PinLimit) ? levels_i[pin_q] : 1'b0;
    pressed  = (lvl == act_q);
    below    = (hold_q < thr_q);
    hold_inc = hold_q + COUNT_WIDTH'(1);
    hold_nx  = hold_q;
    hold_d   = hold_q;
    prog_d   = prog_q;
    fire_o   = 1'b0;
    if (ctl_i.cfg_wr) begin
      hold_d = '0;
      prog_d = PROG_IDLE;
    end else if (ctl_i.tick && mode_q != MODE_NONE) begin
      if (pressed) begin
        hold_nx = below ? hold_inc : hold_q;
        hold_d  = hold_nx;
        if (hold_nx >= thr_q) begin
          case (mode_q)
            MODE_SINGLE: begin
              if (prog_q == PROG_IDLE) begin
                fire_o = 1'b1;
                prog_d = PROG_FIRST;
              end
            end
            MODE_DOUBLE: begin
              if (prog_q == PROG_FIRST) begin
                fire_o = 1'b1;
                prog_d = PROG_DOUBLE;
              end
            end
            MODE_LONG: fire_o = 1'b1;
            default: ;
          endcase
        end
      end else if (mode_q == MODE_DOUBLE) begin
        // released: gap counter runs once the first click is seen
        hold_nx = (below && prog_q != PROG_IDLE) ? hold_inc : hold_q;
        hold_d  = hold_nx;
        if (hold_nx != '0 && hold_nx <= thr_q && prog_q == PROG_IDLE) begin
          prog_d = PROG_FIRST;
        end else if (hold_nx >= thr_q) begin
          hold_d = '0;
          prog_d = PROG_IDLE;
        end
      end else begin
        hold_d = '0;
        prog_d = PROG_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= '0;
      pin_q  <= '0;
      act_q  <= 1'b0;
      mode_q <= MODE_NONE;
      hold_q <= '0;
      prog_q <= PROG_IDLE;
    end else begin
      hold_q <= hold_d;
      prog_q <= prog_d;
      if (ctl_i.cfg_wr) begin
        thr_q  <= cfg_word_i[COUNT_WIDTH-1:0];
        pin_q  <= cfg_word_i[PIN_LSB +: PIN_SEL_W];
        act_q  <= cfg_word_i[ACT_BIT];
        mode_q <= bcd_mode_e'(cfg_word_i[MODE_LSB +: 2]);
      end
    end
  end

  a_hold_le_thr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_q <= thr_q) else $error("hold count above threshold");

  a_prog_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prog_q != 2'd3) else $error("click progress out of range");

  a_single_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_o && !ctl_i.cfg_wr && mode_q == MODE_SINGLE) |=> prog_q == PROG_FIRST)
    else $error("single click fired without latching progress");

endmodule

// ===== hdl/bcd_merge.sv =====
// merging stage: gathers lane fire bits into the result mask register
// depends on bcd_pkg
module bcd_merge #(
  parameter int unsigned SLOTS = bcd_pkg::SLOTS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_valid_i,
  output logic                        s_ready_o,
  input  logic [SLOTS-1:0]            fire_i,
  output logic                        m_valid_o,
  input  logic                        m_ready_i,
  output logic [bcd_pkg::FIRE_W-1:0]  m_mask_o
);
  import bcd_pkg::*;

  logic              valid_q;
  logic [FIRE_W-1:0] mask_q, mask_d;
  logic              accept;

  assign s_ready_o = !valid_q || m_ready_i;
  assign accept    = s_valid_i && s_ready_o;
  assign m_valid_o = valid_q;
  assign m_mask_o  = mask_q;

  always_comb begin
    mask_d            = '0;
    mask_d[SLOTS-1:0] = fire_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (m_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mask_q <= mask_d;
    end
  end

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> valid_q) else $error("tick transfer left no result");

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for button_click_detector_unit: drives pin-level ticks,
// writes slot settings, and compares every fire mask against an in-bench model
// depends on bcd_pkg and the button_click_detector_unit rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bcd_pkg::*;

  // cycles without any transfer or register write before the run is declared hung;
  // the slowest correct run waits at most a sender gap plus a receiver stall
  localparam int unsigned HANG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 4;  // output register plus margin
  localparam int unsigned PHASE_TICKS = 300;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned MAX_PRINTS = 20;
  localparam int unsigned PAIRS = 4;

  // indexes past the last slot pair decode to nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_0 = REG_SLOT_PAIR_0 + 3'd4;
  localparam int unsigned SPARE_REGS = 3;

  typedef struct {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  // dut ports, all inputs known from time zero
  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [PIN_W-1:0]      s_axis_tdata = '0;   // [7:0] pin_levels
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b1;
  logic [FIRE_W-1:0]     m_axis_tdata;        // [7:0] fire_mask
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // model of the block: settings and per-slot state
  logic [ACTIVE_W-1:0]   num_active = '0;
  logic [CFG_DATA_W-1:0] slot_pairs [PAIRS];
  logic [15:0]           hold_cnt [SLOTS_DEF];
  logic [1:0]            click_step [SLOTS_DEF];

  // fire masks predicted for accepted ticks, oldest first
  logic [FIRE_W-1:0]     fire_expect_q [$];
  reg_write_t            pending_writes [$];

  int unsigned           mismatch_count = 0;
  int unsigned           fire_masks_seen = 0;
  int unsigned           burst_left = 0;
  int unsigned           idle_cycles = 0;

  // receiver stall pattern state
  bit                    ready_now = 1'b1;
  int unsigned           ready_left = 0;

  // per-pin run-length generator for press/release sequences
  logic [PIN_W-1:0]      pin_now = '0;
  int unsigned           run_left [PIN_W];

  button_click_detector_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // model of one tick: evaluates every active slot and advances its state
  // ---------------------------------------------------------------------------
  function automatic logic [FIRE_W-1:0] predict_fire_mask(input logic [PIN_W-1:0] levels);
    logic [FIRE_W-1:0]       fire;
    logic [SLOT_WORD_W-1:0]  word;
    logic [15:0]             thr;
    logic [PIN_SEL_W-1:0]    pin;
    logic                    pressed;
    bcd_mode_e               mode;
    int unsigned             n;
    fire = '0;
    // more slots than exist acts as all of them
    n = (num_active > SLOTS_DEF) ? SLOTS_DEF : num_active;
    for (int s = 0; s < n; s++) begin
      word    = slot_pairs[s / 2][(s % 2) * SLOT_WORD_W +: SLOT_WORD_W];
      thr     = word[15:0];
      pin     = word[PIN_LSB +: PIN_SEL_W];
      mode    = bcd_mode_e'(word[MODE_LSB +: 2]);
      pressed = (levels[pin] == word[ACT_BIT]);
      // a slot with no mode is skipped and keeps its state
      if (mode != MODE_NONE) begin
        if (pressed) begin
          if (hold_cnt[s] < thr) hold_cnt[s] = hold_cnt[s] + 16'd1;
          if (hold_cnt[s] >= thr) begin
            case (mode)
              MODE_SINGLE: begin
                if (click_step[s] == 2'd0) begin
                  fire[s] = 1'b1;
                  click_step[s] = 2'd1;
                end
              end
              MODE_DOUBLE: begin
                if (click_step[s] == 2'd1) begin
                  fire[s] = 1'b1;
                  click_step[s] = 2'd2;
                end
              end
              default: fire[s] = 1'b1;  // long press fires on every tick at threshold
            endcase
          end
        end else if (mode == MODE_DOUBLE) begin
          // released between clicks: the release window keeps counting
          if (hold_cnt[s] < thr && click_step[s] != 2'd0) hold_cnt[s] = hold_cnt[s] + 16'd1;
          if (hold_cnt[s] != 16'd0 && hold_cnt[s] <= thr && click_step[s] == 2'd0) begin
            click_step[s] = 2'd1;
          end else if (hold_cnt[s] >= thr) begin
            hold_cnt[s]   = '0;
            click_step[s] = '0;
          end
        end else begin
          hold_cnt[s]   = '0;
          click_step[s] = '0;
        end
      end
    end
    return fire;
  endfunction

  // register write as seen by the model; unknown indexes change nothing
  function automatic void model_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
    int unsigned k;
    if (idx == REG_ACTIVE_SLOTS) begin
      num_active = data[ACTIVE_W-1:0];
    end else if (idx >= REG_SLOT_PAIR_0 && idx < REG_SPARE_0) begin
      k = idx - REG_SLOT_PAIR_0;
      slot_pairs[k] = data;
      // writing a pair clears both of its slots
      hold_cnt[2 * k]       = '0;
      click_step[2 * k]     = '0;
      hold_cnt[2 * k + 1]   = '0;
      click_step[2 * k + 1] = '0;
    end
  endfunction

  // slot word with random filler in the unused upper bits
  function automatic logic [SLOT_WORD_W-1:0] slot_word(input logic [15:0] thr,
                                                       input logic [PIN_SEL_W-1:0] pin,
                                                       input logic act,
                                                       input bcd_mode_e mode);
    logic [SLOT_WORD_W-1:0] word;
    word = $urandom;
    word[15:0]                  = thr;
    word[PIN_LSB +: PIN_SEL_W]  = pin;
    word[ACT_BIT]               = act;
    word[MODE_LSB +: 2]         = mode;
    return word;
  endfunction

  // mostly short thresholds so events happen often, a few long and the widest
  function automatic logic [15:0] pick_threshold();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 16'hFFFF;
    if (r == 1) return 16'($urandom);
    if (r <= 4) return 16'($urandom_range(7, 40));
    return 16'($urandom_range(0, 6));
  endfunction

  // next pin levels: every pin holds its level for a random run, with the odd
  // fully random tick thrown in as noise
  function automatic logic [PIN_W-1:0] next_pin_levels();
    if ($urandom_range(0, 9) == 0) return PIN_W'($urandom);
    for (int p = 0; p < PIN_W; p++) begin
      if (run_left[p] == 0) begin
        pin_now[p]  = ~pin_now[p];
        run_left[p] = ($urandom_range(0, 5) == 0) ? $urandom_range(6, 50)
                                                  : $urandom_range(1, 5);
      end
      run_left[p]--;
    end
    return pin_now;
  endfunction

  function automatic void stage_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
    reg_write_t w;
    w.idx  = idx;
    w.data = data;
    pending_writes.push_back(w);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] active_word(input logic [ACTIVE_W-1:0] n);
    logic [CFG_DATA_W-1:0] data;
    data = {$urandom, $urandom};
    data[ACTIVE_W-1:0] = n;
    return data;
  endfunction

  // ---------------------------------------------------------------------------
  // sender: one tick per call, in bursts with random gaps
  // ---------------------------------------------------------------------------
  task automatic send_tick(input logic [PIN_W-1:0] levels);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 24);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= levels;
    do @(posedge clk_i); while (!s_axis_tready);
    // the tick transfer happened at this edge
    fire_expect_q.push_back(predict_fire_mask(levels));
  endtask

  // block must be idle for register writes: stop sending, let every
  // expected fire mask arrive, then write back to back
  task automatic commit_writes();
    reg_write_t w;
    s_axis_tvalid <= 1'b0;
    while (fire_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    while (pending_writes.size() != 0) begin
      w = pending_writes.pop_front();
      cfg_we_i    <= 1'b1;
      cfg_index_i <= w.idx;
      cfg_data_i  <= w.data;
      @(posedge clk_i);
      model_write(w.idx, w.data);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string what, input logic [FIRE_W-1:0] got,
                                 input logic [FIRE_W-1:0] want);
    if (mismatch_count < MAX_PRINTS) begin
      $display("[%0t] mismatch at fire mask %0d: %s got %02h expected %02h",
               $realtime, fire_masks_seen, what, got, want);
    end
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // receiver: stalls in runs, sometimes long stretches without stalling
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (ready_left != 0) begin
      ready_left--;
    end else begin
      if (ready_now) begin
        ready_now  = 1'b0;
        ready_left = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 2);
      end else begin
        ready_now  = 1'b1;
        ready_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(0, 6);
      end
      m_axis_tready <= ready_now;
    end
  end

  // checker: every fire mask transfer against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (fire_expect_q.size() == 0) begin
        report_mismatch("unexpected transfer", m_axis_tdata, '0);
      end else if (m_axis_tdata !== fire_expect_q[0]) begin
        report_mismatch("fire_mask", m_axis_tdata, fire_expect_q[0]);
        void'(fire_expect_q.pop_front());
      end else begin
        void'(fire_expect_q.pop_front());
      end
      fire_masks_seen++;
    end
  end

  // watchdog: ends a run that stops making progress
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= HANG_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // out of reset no slot is active, so nothing may fire
  task automatic test_reset_state();
    send_tick(8'h00);
    send_tick(8'hFF);
    send_tick(8'hA5);
    send_tick(8'h5A);
  endtask

  // every mode with zero, one and widest thresholds, both active levels
  task automatic test_modes();
    stage_write(REG_SLOT_PAIR_0,
                {slot_word(16'd2, 3'd1, 1'b1, MODE_SINGLE), slot_word(16'd0, 3'd0, 1'b1, MODE_SINGLE)});
    stage_write(REG_SLOT_PAIR_0 + 3'd1,
                {slot_word(16'd3, 3'd3, 1'b1, MODE_LONG), slot_word(16'd0, 3'd2, 1'b1, MODE_LONG)});
    stage_write(REG_SLOT_PAIR_0 + 3'd2,
                {slot_word(16'd0, 3'd5, 1'b1, MODE_DOUBLE), slot_word(16'd2, 3'd4, 1'b1, MODE_DOUBLE)});
    stage_write(REG_SLOT_PAIR_0 + 3'd3,
                {slot_word(16'hFFFF, 3'd7, 1'b0, MODE_LONG), slot_word(16'd1, 3'd6, 1'b1, MODE_NONE)});
    stage_write(REG_ACTIVE_SLOTS, active_word(4'd8));
    commit_writes();
    // press, short release, press again: double click window; long holds
    send_tick(8'hFF);
    send_tick(8'h00);
    send_tick(8'hFF);
    send_tick(8'hFF);
    send_tick(8'hFF);
    send_tick(8'hFF);
    send_tick(8'h00);
    send_tick(8'h00);
    send_tick(8'h00);
    send_tick(8'hFF);
    send_tick(8'h7F);
    send_tick(8'h00);
  endtask

  // slot count extremes, ignored register indexes, and a rewrite mid-press
  task automatic test_slot_limits();
    stage_write(REG_ACTIVE_SLOTS, active_word(4'hF));
    commit_writes();
    send_tick(8'hFF);
    send_tick(8'hFF);
    for (int i = 0; i < SPARE_REGS; i++) stage_write(REG_SPARE_0 + CFG_IDX_W'(i), {$urandom, $urandom});
    commit_writes();
    send_tick(8'hFF);
    stage_write(REG_ACTIVE_SLOTS, active_word(4'd0));
    commit_writes();
    send_tick(8'hFF);
    stage_write(REG_ACTIVE_SLOTS, active_word(4'd3));
    stage_write(REG_SLOT_PAIR_0 + 3'd1,
                {slot_word(16'd1, 3'd3, 1'b1, MODE_LONG), slot_word(16'd1, 3'd2, 1'b0, MODE_SINGLE)});
    commit_writes();
    send_tick(8'h08);
    send_tick(8'h00);
    send_tick(8'hFB);
  endtask

  // random phases: new settings each phase, press/release runs per pin
  task automatic test_random_runs();
    logic [15:0]          thr_lo, thr_hi;
    logic [ACTIVE_W-1:0]  n;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      for (int k = 0; k < PAIRS; k++) begin
        case (ph)
          0: begin thr_lo = 16'd0; thr_hi = 16'd0; end
          1: begin thr_lo = 16'd1; thr_hi = 16'd1; end
          default: begin thr_lo = pick_threshold(); thr_hi = pick_threshold(); end
        endcase
        stage_write(REG_SLOT_PAIR_0 + CFG_IDX_W'(k),
                    {slot_word(thr_hi, PIN_SEL_W'($urandom), 1'($urandom),
                               bcd_mode_e'(2'($urandom))),
                     slot_word(thr_lo, PIN_SEL_W'($urandom), 1'($urandom),
                               bcd_mode_e'(2'($urandom)))});
      end
      case (ph)
        0: n = 4'd8;
        1: n = 4'hF;
        2: n = ACTIVE_W'($urandom_range(1, 7));
        default: n = ($urandom_range(0, 1) == 0) ? 4'd8 : ACTIVE_W'($urandom);
      endcase
      stage_write(REG_ACTIVE_SLOTS, active_word(n));
      commit_writes();
      for (int i = 0; i < PHASE_TICKS; i++) send_tick(next_pin_levels());
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int k = 0; k < PAIRS; k++) slot_pairs[k] = '0;
    for (int s = 0; s < SLOTS_DEF; s++) begin
      hold_cnt[s]   = '0;
      click_step[s] = '0;
    end
    for (int p = 0; p < PIN_W; p++) run_left[p] = $urandom_range(1, 5);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_modes();
    test_slot_limits();
    test_random_runs();

    // all ticks sent: drain outstanding fire masks, then a short settle
    s_axis_tvalid <= 1'b0;
    while (fire_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
